FILE: src/linear_queue_with_search_top_macros.svh
// Assertion macros used by the queue top level.
`ifndef LINEAR_QUEUE_WITH_SEARCH_TOP_MACROS_SVH
`define LINEAR_QUEUE_WITH_SEARCH_TOP_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define LQS_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold on the same edge as the antecedent.
`define LQS_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define LQS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/lqs_pkg.sv
// Shared constants, codes and types of the linear queue with search.
package lqs_pkg;

  // Number of slots, the counter width that follows from it, and the other widths.
  localparam int unsigned Depth  = 8;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned DataW  = 32;
  localparam int unsigned CountW = 4;
  localparam int unsigned OpW    = 3;
  localparam int unsigned StatW  = 2;

  // Data returned by a removal or peek on an empty queue.
  localparam logic [DataW-1:0] EmptyData = '1;

  typedef enum logic [OpW-1:0] {
    OP_ENQ    = 3'd0,
    OP_DEQ    = 3'd1,
    OP_FRONT  = 3'd2,
    OP_REAR   = 3'd3,
    OP_SEARCH = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Per-cell control from the queue controller.
  typedef struct packed {
    logic load;   // take the broadcast value into this cell
    logic shift;  // take the value of the next cell toward the rear
    logic live;   // this cell holds a live entry
  } cell_ctrl_t;

endpackage

FILE: src/lqs_cell.sv
// One storage cell of the queue: holds an entry, shifts toward the front, compares a key.
module lqs_cell (
  input  logic                            clk_i,
  input  lqs_pkg::cell_ctrl_t             ctrl_i,
  input  logic [lqs_pkg::DataW-1:0]       value_i,
  input  logic [lqs_pkg::DataW-1:0]       next_i,
  input  logic                            found_i,
  output logic [lqs_pkg::DataW-1:0]       data_o,
  output logic                            found_o
);

  logic [lqs_pkg::DataW-1:0] data_q;
  logic [lqs_pkg::DataW-1:0] data_d;

  // A dequeue moves every entry one cell toward the front; an enqueue fills one cell.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift) begin
      data_d = next_i;
    end else if (ctrl_i.load) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // The match flag ripples from the front cell to the rear cell.
  assign found_o = found_i | (ctrl_i.live && (data_q == value_i));
  assign data_o  = data_q;

endmodule

FILE: src/linear_queue_with_search_top.sv
// Top level of the linear queue with search: controller, cell chain and result register.
//
// Usage: requests enter on the input channel (in_valid_i, in_stall_o) as an
// operation code and a 32-bit value; each request yields exactly one result on
// the output channel (out_valid_o, out_stall_i) carrying data, found, count and
// status. Operations are enqueue, dequeue, peek front, peek rear, search and
// clear. The queue is linear: slots freed by dequeue come back only on clear.
// The result is registered and appears in the cycle after acceptance; one
// request is taken per cycle unless the receiver stalls. All slots sit in a
// chain of cells; a dequeue shifts every cell one place toward the front in
// its cycle, and a search compares the key in every cell at once with the
// match flag rippling down the chain. The rear entry has its own register.
// Reset clears the entry counters and the result valid flag; slot contents
// are not cleared and are never read before being written. When the receiver
// stalls, the result register holds its result and the input stalls in the
// same cycle, so no request is taken until the result has been delivered.
module linear_queue_with_search_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lqs_pkg::OpW-1:0]    operation_i,
  input  logic signed [lqs_pkg::DataW-1:0] value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [lqs_pkg::DataW-1:0] data_o,
  output logic                       found_o,
  output logic [lqs_pkg::CountW-1:0] count_o,
  output logic [lqs_pkg::StatW-1:0]  status_o
);

  `include "linear_queue_with_search_top_macros.svh"

  localparam int unsigned Depth = lqs_pkg::Depth;
  localparam int unsigned CntW  = lqs_pkg::CntW;
  localparam int unsigned DataW = lqs_pkg::DataW;

  logic [CntW-1:0]  head_q, head_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic [DataW-1:0] rear_q, rear_d;
  logic             out_valid_q;
  logic [DataW-1:0] res_data_q, res_data_d;
  logic             res_found_q, res_found_d;
  logic [lqs_pkg::CountW-1:0] res_count_q, res_count_d;
  lqs_pkg::status_e res_status_q, res_status_d;

  logic             in_acc;
  logic             enq_go, deq_go;
  logic [CntW-1:0]  live_cnt;
  logic             empty, full;

  logic [Depth-1:0][DataW-1:0] cell_data;
  logic [Depth:0]              found_chain;
  lqs_pkg::cell_ctrl_t [Depth-1:0] cell_ctrl;

  // Handshake: a request is taken whenever the result register is free or draining.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign live_cnt = fill_q - head_q;
  assign empty    = (live_cnt == '0);
  assign full     = (fill_q == CntW'(Depth));

  // Operation decode and next state.
  always_comb begin
    head_d       = head_q;
    fill_d       = fill_q;
    rear_d       = rear_q;
    enq_go       = 1'b0;
    deq_go       = 1'b0;
    res_data_d   = '0;
    res_found_d  = 1'b0;
    res_status_d = lqs_pkg::ST_OK;
    case (lqs_pkg::op_e'(operation_i))
      lqs_pkg::OP_ENQ: begin
        if (full) begin
          res_status_d = lqs_pkg::ST_FULL;
        end else begin
          fill_d = fill_q + 1'b1;
          rear_d = value_i;
          enq_go = 1'b1;
        end
      end
      lqs_pkg::OP_DEQ: begin
        if (empty) begin
          res_data_d   = lqs_pkg::EmptyData;
          res_status_d = lqs_pkg::ST_EMPTY;
        end else begin
          res_data_d = cell_data[0];
          head_d     = head_q + 1'b1;
          deq_go     = 1'b1;
        end
      end
      lqs_pkg::OP_FRONT: begin
        if (empty) begin
          res_data_d   = lqs_pkg::EmptyData;
          res_status_d = lqs_pkg::ST_EMPTY;
        end else begin
          res_data_d = cell_data[0];
        end
      end
      lqs_pkg::OP_REAR: begin
        if (empty) begin
          res_data_d   = lqs_pkg::EmptyData;
          res_status_d = lqs_pkg::ST_EMPTY;
        end else begin
          res_data_d = rear_q;
        end
      end
      lqs_pkg::OP_SEARCH: begin
        res_found_d = found_chain[Depth];
      end
      lqs_pkg::OP_CLEAR: begin
        head_d = '0;
        fill_d = '0;
      end
      default: begin
      end
    endcase
    res_count_d = lqs_pkg::CountW'(fill_d - head_d);
  end

  // Cell chain: the front entry lives in cell 0.
  assign found_chain[0] = 1'b0;
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataW-1:0] next_data;
    if (i == Depth - 1) begin : g_last
      assign next_data = '0;
    end else begin : g_mid
      assign next_data = cell_data[i+1];
    end

    assign cell_ctrl[i].load  = in_acc && enq_go && (live_cnt == CntW'(i));
    assign cell_ctrl[i].shift = in_acc && deq_go;
    assign cell_ctrl[i].live  = (CntW'(i) < live_cnt);

    lqs_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .value_i (value_i),
      .next_i  (next_data),
      .found_i (found_chain[i]),
      .data_o  (cell_data[i]),
      .found_o (found_chain[i+1])
    );
  end

  // Control state: counters and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        head_q <= head_d;
        fill_q <= fill_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: rear entry and the result fields.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rear_q       <= rear_d;
      res_data_q   <= res_data_d;
      res_found_q  <= res_found_d;
      res_count_q  <= res_count_d;
      res_status_q <= res_status_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = res_data_q;
  assign found_o     = res_found_q;
  assign count_o     = res_count_q;
  assign status_o    = res_status_q;

  // Checks on the counters and the result register.
  `LQS_ASSERT_ALWAYS(a_head_le_fill, clk_i, rst_ni, head_q <= fill_q, "head passed fill")
  `LQS_ASSERT_ALWAYS(a_fill_le_depth, clk_i, rst_ni, fill_q <= CntW'(Depth), "fill beyond depth")
  `LQS_ASSERT_NEXT(a_acc_gives_result, clk_i, rst_ni, in_acc, out_valid_q, "result lost")
  `LQS_ASSERT_IMPLIES(a_full_state, clk_i, rst_ni, out_valid_q && (res_status_q == lqs_pkg::ST_FULL), fill_q == CntW'(Depth), "full status without full queue")

endmodule
